FILE: src/shps_pkg.sv
// Shared types, codes and constants of the stepper homing and plunge sequencer.
package shps_pkg;

  // Default widths of the datapath
  localparam int READING_BITS_DEF      = 24;
  localparam int POSITION_BITS_DEF     = 21;
  localparam int SAMPLE_COUNT_BITS_DEF = 22;

  // Configuration port and register widths
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int TICKS_W     = 16;
  localparam int STEPS_W     = 20;
  localparam int DEV_LIMIT_W = 24;
  localparam int RUN_W       = 16;

  // Register reset values
  localparam logic [TICKS_W-1:0]     STEP_HIGH_RST    = 16'd10;
  localparam logic [TICKS_W-1:0]     STEP_LOW_RST     = 16'd10;
  localparam logic [STEPS_W-1:0]     HOME_OFFSET_RST  = 20'd0;
  localparam logic [STEPS_W-1:0]     PLUNGE_LIMIT_RST = 20'hFFFFF;
  localparam logic [DEV_LIMIT_W-1:0] DEV_LIMIT_RST    = 24'd100000;
  localparam logic [RUN_W-1:0]       RUN_LIMIT_RST    = 16'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_HIGH    = 3'd0,
    CFG_STEP_LOW     = 3'd1,
    CFG_HOME_OFFSET  = 3'd2,
    CFG_PLUNGE_LIMIT = 3'd3,
    CFG_DEV_LIMIT    = 3'd4,
    CFG_RUN_LIMIT    = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_HOME   = 2'd1,
    KIND_PLUNGE = 2'd2,
    KIND_STOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_UP     = 2'd1,
    PH_DOWN   = 2'd2,
    PH_PLUNGE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_SENSOR   = 3'd1,
    CAUSE_LIMIT    = 3'd2,
    CAUSE_OVERLOAD = 3'd3,
    CAUSE_STOP     = 3'd4
  } cause_t;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CMD_HOME,
    OP_CMD_PLUNGE,
    OP_CMD_STOP,
    OP_UP_TRIP,
    OP_START_STEP,
    OP_ZERO_AVG,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_FIN_REHOME,
    OP_FIN_IDLE,
    OP_PLUNGE_END,
    OP_TICK,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t    op;
    cause_t cause;
  } cmd_t;

  typedef struct packed {
    kind_t  kind;
    phase_t phase;
    logic   stop_pending;
    logic   sensor;
    logic   pos_lt_offset;
    logic   pos_ge_limit;
    logic   count_zero;
    logic   rehome_after;
    logic   step_busy;
    logic   div_last;
  } sts_t;

endpackage

FILE: src/shps_ctrl.sv
// Sequencer controller: walks each item through dispatch, phase decisions, divide, tick, emit.
module shps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  shps_pkg::sts_t  sts,
  output shps_pkg::cmd_t  cmd
);
  import shps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_BOUND,
    S_DIV,
    S_DIV_DONE,
    S_FIN,
    S_CALC,
    S_TICK,
    S_EMIT
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  cause_t plunge_cause;

  // Pick the reason a plunge stroke ends at a step start
  always_comb begin
    if (sts.stop_pending) begin
      plunge_cause = CAUSE_STOP;
    end else if (sts.sensor) begin
      plunge_cause = CAUSE_SENSOR;
    end else if (sts.pos_ge_limit) begin
      plunge_cause = CAUSE_LIMIT;
    end else begin
      plunge_cause = CAUSE_NONE;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_next     = state;
    cmd.op         = OP_NONE;
    cmd.cause      = plunge_cause;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op     = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_EMIT;
        case (sts.kind)
          KIND_HOME: begin
            if (sts.phase == PH_IDLE) cmd.op = OP_CMD_HOME;
          end
          KIND_PLUNGE: begin
            if (sts.phase == PH_IDLE) cmd.op = OP_CMD_PLUNGE;
          end
          KIND_STOP: begin
            if (sts.phase != PH_IDLE) cmd.op = OP_CMD_STOP;
          end
          default: begin
            if (sts.phase != PH_IDLE) state_next = sts.step_busy ? S_CALC : S_BOUND;
          end
        endcase
      end
      S_BOUND: begin
        case (sts.phase)
          PH_UP: begin
            if (sts.stop_pending || sts.sensor) begin
              cmd.op = OP_UP_TRIP;
            end else begin
              cmd.op     = OP_START_STEP;
              state_next = S_CALC;
            end
          end
          PH_DOWN: begin
            if (!sts.stop_pending && sts.pos_lt_offset) begin
              cmd.op     = OP_START_STEP;
              state_next = S_CALC;
            end else if (sts.count_zero) begin
              cmd.op     = OP_ZERO_AVG;
              state_next = S_FIN;
            end else begin
              cmd.op     = OP_DIV_START;
              state_next = S_DIV;
            end
          end
          PH_PLUNGE: begin
            if (plunge_cause == CAUSE_NONE) begin
              cmd.op     = OP_START_STEP;
              state_next = S_CALC;
            end else begin
              cmd.op = OP_PLUNGE_END;
            end
          end
          default: state_next = S_CALC;
        endcase
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) state_next = S_DIV_DONE;
      end
      S_DIV_DONE: begin
        cmd.op     = OP_DIV_DONE;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.rehome_after) begin
          cmd.op     = OP_FIN_REHOME;
          state_next = S_BOUND;
        end else begin
          cmd.op     = OP_FIN_IDLE;
          state_next = S_CALC;
        end
      end
      // wait state for the deviation register to follow the zero offset
      S_CALC: state_next = S_TICK;
      S_TICK: begin
        cmd.op     = OP_TICK;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= out_valid_next;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice without finishing the item");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_START_STEP |-> !sts.step_busy)
    else $error("step started while a step is in progress");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DIV_START |-> !sts.count_zero)
    else $error("divide started with an empty sample count");

  a_div_flow: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> (state == S_DIV || state == S_DIV_DONE))
    else $error("divide left early");

endmodule

FILE: src/shps_dpath.sv
// Sequencer datapath: configuration, motion state, averaging divider and result register.
module shps_dpath #(
  parameter int READING_BITS      = shps_pkg::READING_BITS_DEF,
  parameter int POSITION_BITS     = shps_pkg::POSITION_BITS_DEF,
  parameter int SAMPLE_COUNT_BITS = shps_pkg::SAMPLE_COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [shps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [shps_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [1:0]                           kind,
  input  logic                                 stop_sensor,
  input  logic signed [READING_BITS-1:0]       load_reading,
  input  shps_pkg::cmd_t                       cmd,
  output shps_pkg::sts_t                       sts,
  output logic                                 step_out,
  output logic                                 direction_out,
  output logic                                 enable_out,
  output logic                                 busy_res,
  output logic [1:0]                           phase,
  output logic signed [POSITION_BITS-1:0]      position,
  output logic signed [READING_BITS-1:0]       zero_offset,
  output logic                                 position_valid,
  output logic                                 sample_valid,
  output logic signed [POSITION_BITS-1:0]      sample_position,
  output logic signed [READING_BITS-1:0]       sample_reading,
  output logic [2:0]                           plunge_end_cause
);
  import shps_pkg::*;

  localparam int SUM_W     = READING_BITS + SAMPLE_COUNT_BITS;
  localparam int DEV_W     = READING_BITS + 1;
  localparam int CMP_W     = (DEV_W > DEV_LIMIT_W) ? DEV_W : DEV_LIMIT_W;
  localparam int PC_W      = ((POSITION_BITS > STEPS_W) ? POSITION_BITS : STEPS_W) + 1;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};
  localparam logic signed [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  // Configuration registers
  logic [TICKS_W-1:0]     step_high_ticks, step_low_ticks;
  logic [STEPS_W-1:0]     home_offset_steps, plunge_step_limit;
  logic [DEV_LIMIT_W-1:0] load_deviation_limit;
  logic [RUN_W-1:0]       overload_run_limit;

  // Sequence state
  phase_t                        seq_phase;
  logic [TICKS_W-1:0]            tick_count;
  logic                          pulse_high;
  logic signed [POSITION_BITS-1:0] step_position;
  logic signed [READING_BITS-1:0]  zero_average;
  logic                          homed_flag;
  logic signed [SUM_W-1:0]       reading_sum;
  logic [SAMPLE_COUNT_BITS-1:0]  reading_count;
  logic [RUN_W-1:0]              overload_run;
  logic                          stop_pending;
  logic                          rehome_after;
  cause_t                        last_cause;

  // Latched item and per-item results
  kind_t                         in_kind;
  logic                          in_sensor;
  logic signed [READING_BITS-1:0]  in_reading;
  logic                          step_level;
  logic                          smp_valid;
  logic signed [POSITION_BITS-1:0] smp_pos;
  logic signed [READING_BITS-1:0]  smp_read;

  // Divider
  logic [SUM_W-1:0]              div_q;
  logic [SAMPLE_COUNT_BITS-1:0]  div_rem;
  logic                          div_neg;
  logic [DIV_CNT_W-1:0]          div_cnt;

  logic [DEV_W-1:0]              dev_reg;

  // Combinational helpers
  logic [TICKS_W-1:0]            high_eff, low_eff, tick_dec;
  logic                          step_busy;
  logic signed [POSITION_BITS-1:0] pos_inc, pos_dec;
  logic signed [SUM_W-1:0]       sum_add;
  logic                          count_full;
  logic [SUM_W-1:0]              sum_mag;
  logic [SAMPLE_COUNT_BITS:0]    trial, trial_diff;
  logic                          trial_ok;
  logic signed [READING_BITS-1:0]  quot;
  logic signed [DEV_W-1:0]       diff;
  logic [DEV_W-1:0]              dev_abs;
  logic                          overloaded, ended;
  logic [RUN_W-1:0]              run_inc;
  logic signed [PC_W-1:0]        pos_ext, offset_ext, limit_ext;

  assign high_eff   = (step_high_ticks == '0) ? TICKS_W'(1) : step_high_ticks;
  assign low_eff    = (step_low_ticks == '0) ? TICKS_W'(1) : step_low_ticks;
  assign tick_dec   = tick_count - TICKS_W'(1);
  assign step_busy  = pulse_high || (tick_count != '0);

  // Saturating position moves
  assign pos_inc = (step_position == POS_MAX) ? step_position : step_position + POS_ONE;
  assign pos_dec = (step_position == POS_MIN) ? step_position : step_position - POS_ONE;

  // Accumulator for the zero offset average
  assign sum_add    = reading_sum + SUM_W'(in_reading);
  assign count_full = (reading_count == '1);

  // Restoring divide on the magnitude, one quotient bit a cycle
  assign sum_mag    = reading_sum[SUM_W-1] ? SUM_W'(-reading_sum) : SUM_W'(reading_sum);
  assign trial      = {div_rem, div_q[SUM_W-1]};
  assign trial_ok   = trial >= {1'b0, reading_count};
  assign trial_diff = trial - {1'b0, reading_count};
  assign quot       = $signed(div_q[READING_BITS-1:0]);

  // Load deviation from the zero offset
  assign diff    = DEV_W'(in_reading) - DEV_W'(zero_average);
  assign dev_abs = diff[DEV_W-1] ? DEV_W'(-diff) : DEV_W'(diff);
  assign overloaded = CMP_W'(dev_reg) > CMP_W'(load_deviation_limit);
  assign run_inc    = (overload_run == '1) ? overload_run : overload_run + RUN_W'(1);
  assign ended      = overloaded && (run_inc >= overload_run_limit);

  // Position compares against unsigned step settings
  assign pos_ext    = PC_W'(step_position);
  assign offset_ext = $signed(PC_W'(home_offset_steps));
  assign limit_ext  = $signed(PC_W'(plunge_step_limit));

  // Status to the controller
  always_comb begin
    sts.kind          = in_kind;
    sts.phase         = seq_phase;
    sts.stop_pending  = stop_pending;
    sts.sensor        = in_sensor;
    sts.pos_lt_offset = pos_ext < offset_ext;
    sts.pos_ge_limit  = pos_ext >= limit_ext;
    sts.count_zero    = (reading_count == '0);
    sts.rehome_after  = rehome_after;
    sts.step_busy     = step_busy;
    sts.div_last      = (div_cnt == DIV_CNT_W'(1));
  end

  // Register the deviation magnitude
  always_ff @(posedge clk) begin
    dev_reg <= dev_abs;
  end

  // Configuration and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_high_ticks      <= STEP_HIGH_RST;
      step_low_ticks       <= STEP_LOW_RST;
      home_offset_steps    <= HOME_OFFSET_RST;
      plunge_step_limit    <= PLUNGE_LIMIT_RST;
      load_deviation_limit <= DEV_LIMIT_RST;
      overload_run_limit   <= RUN_LIMIT_RST;
      seq_phase            <= PH_IDLE;
      tick_count           <= '0;
      pulse_high           <= 1'b0;
      step_position        <= '0;
      zero_average         <= '0;
      homed_flag           <= 1'b0;
      reading_sum          <= '0;
      reading_count        <= '0;
      overload_run         <= '0;
      stop_pending         <= 1'b0;
      rehome_after         <= 1'b0;
      last_cause           <= CAUSE_NONE;
      step_level           <= 1'b0;
      smp_valid            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_HIGH:    step_high_ticks      <= cfg_data[TICKS_W-1:0];
          CFG_STEP_LOW:     step_low_ticks       <= cfg_data[TICKS_W-1:0];
          CFG_HOME_OFFSET:  home_offset_steps    <= cfg_data[STEPS_W-1:0];
          CFG_PLUNGE_LIMIT: plunge_step_limit    <= cfg_data[STEPS_W-1:0];
          CFG_DEV_LIMIT:    load_deviation_limit <= cfg_data[DEV_LIMIT_W-1:0];
          CFG_RUN_LIMIT:    overload_run_limit   <= cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LATCH: begin
          in_kind    <= kind_t'(kind);
          in_sensor  <= stop_sensor;
          in_reading <= load_reading;
          step_level <= 1'b0;
          smp_valid  <= 1'b0;
        end
        OP_CMD_HOME: begin
          stop_pending  <= 1'b0;
          rehome_after  <= 1'b0;
          seq_phase     <= PH_UP;
          reading_sum   <= '0;
          reading_count <= '0;
          tick_count    <= '0;
          pulse_high    <= 1'b0;
        end
        OP_CMD_PLUNGE: begin
          stop_pending <= 1'b0;
          last_cause   <= CAUSE_NONE;
          overload_run <= '0;
          tick_count   <= '0;
          pulse_high   <= 1'b0;
          if (homed_flag) begin
            rehome_after <= 1'b0;
            seq_phase    <= PH_PLUNGE;
          end else begin
            rehome_after  <= 1'b1;
            seq_phase     <= PH_UP;
            reading_sum   <= '0;
            reading_count <= '0;
          end
        end
        OP_CMD_STOP: stop_pending <= 1'b1;
        OP_UP_TRIP: begin
          step_position <= '0;
          seq_phase     <= PH_DOWN;
        end
        OP_START_STEP: begin
          pulse_high <= 1'b1;
          tick_count <= high_eff;
        end
        OP_ZERO_AVG: zero_average <= '0;
        OP_DIV_START: begin
          div_q   <= sum_mag;
          div_rem <= '0;
          div_neg <= reading_sum[SUM_W-1];
          div_cnt <= DIV_CNT_W'(SUM_W);
        end
        OP_DIV_STEP: begin
          div_rem <= trial_ok ? trial_diff[SAMPLE_COUNT_BITS-1:0]
                              : trial[SAMPLE_COUNT_BITS-1:0];
          div_q   <= {div_q[SUM_W-2:0], trial_ok};
          div_cnt <= div_cnt - DIV_CNT_W'(1);
        end
        OP_DIV_DONE: zero_average <= div_neg ? -quot : quot;
        OP_FIN_REHOME: begin
          homed_flag   <= 1'b1;
          rehome_after <= 1'b0;
          seq_phase    <= PH_PLUNGE;
          overload_run <= '0;
        end
        OP_FIN_IDLE: begin
          homed_flag   <= 1'b1;
          seq_phase    <= PH_IDLE;
          stop_pending <= 1'b0;
        end
        OP_PLUNGE_END: begin
          last_cause    <= cmd.cause;
          seq_phase     <= PH_UP;
          reading_sum   <= '0;
          reading_count <= '0;
          tick_count    <= '0;
          pulse_high    <= 1'b0;
        end
        OP_TICK: begin
          if (step_busy) begin
            step_level <= pulse_high;
            if (tick_dec != '0) begin
              tick_count <= tick_dec;
            end else if (pulse_high) begin
              pulse_high <= 1'b0;
              tick_count <= low_eff;
            end else begin
              // last low tick: move and take the reading
              tick_count <= '0;
              case (seq_phase)
                PH_UP: begin
                  step_position <= pos_dec;
                  if (!count_full) begin
                    reading_sum   <= sum_add;
                    reading_count <= reading_count + SAMPLE_COUNT_BITS'(1);
                  end
                end
                PH_DOWN: begin
                  step_position <= pos_inc;
                  if (!count_full) begin
                    reading_sum   <= sum_add;
                    reading_count <= reading_count + SAMPLE_COUNT_BITS'(1);
                  end
                end
                PH_PLUNGE: begin
                  smp_valid    <= 1'b1;
                  smp_pos      <= step_position;
                  smp_read     <= in_reading;
                  overload_run <= overloaded ? run_inc : '0;
                  if (ended) begin
                    last_cause    <= CAUSE_OVERLOAD;
                    seq_phase     <= PH_UP;
                    reading_sum   <= '0;
                    reading_count <= '0;
                  end else begin
                    step_position <= pos_inc;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register, loaded once per item
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      step_out         <= step_level;
      direction_out    <= (seq_phase == PH_IDLE) ? homed_flag : (seq_phase != PH_UP);
      enable_out       <= (seq_phase != PH_IDLE);
      busy_res         <= (seq_phase != PH_IDLE);
      phase            <= seq_phase;
      position         <= step_position;
      zero_offset      <= zero_average;
      position_valid   <= homed_flag;
      sample_valid     <= smp_valid;
      sample_position  <= smp_valid ? smp_pos : '0;
      sample_reading   <= smp_valid ? smp_read : '0;
      plunge_end_cause <= last_cause;
    end
  end

  a_pulse_timed: assert property (@(posedge clk) disable iff (rst)
    pulse_high |-> tick_count != '0)
    else $error("step pulse high with no tick budget");

  a_idle_no_stop: assert property (@(posedge clk) disable iff (rst)
    seq_phase == PH_IDLE |-> !stop_pending)
    else $error("stop request left pending while idle");

  a_homed_sticky: assert property (@(posedge clk) disable iff (rst)
    homed_flag |=> homed_flag)
    else $error("position valid dropped");

endmodule

FILE: src/stepper_homing_plunge_sequencer_unit.sv
// Top level of the stepper homing and plunge sequencer.
// One beat in gives one beat out. A command passes through accept, dispatch and
// emit; a tick inside a step also passes the deviation register and the tick
// update before emit. A tick at a step boundary adds the phase decisions chained
// in it, and a tick that ends a homing with samples adds the averaging divide,
// run by the restoring divider that retires one quotient bit a cycle. A new item
// is taken while the previous result still waits at the output register.
module stepper_homing_plunge_sequencer_unit #(
  parameter int READING_BITS      = shps_pkg::READING_BITS_DEF,
  parameter int POSITION_BITS     = shps_pkg::POSITION_BITS_DEF,
  parameter int SAMPLE_COUNT_BITS = shps_pkg::SAMPLE_COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [shps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [shps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         kind,
  input  logic                               stop_sensor,
  input  logic signed [READING_BITS-1:0]     load_reading,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               step_out,
  output logic                               direction_out,
  output logic                               enable_out,
  output logic                               busy_res,
  output logic [1:0]                         phase,
  output logic signed [POSITION_BITS-1:0]    position,
  output logic signed [READING_BITS-1:0]     zero_offset,
  output logic                               position_valid,
  output logic                               sample_valid,
  output logic signed [POSITION_BITS-1:0]    sample_position,
  output logic signed [READING_BITS-1:0]     sample_reading,
  output logic [2:0]                         plunge_end_cause
);
  import shps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence control
  shps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Motion state, divider and result register
  shps_dpath #(
    .READING_BITS      (READING_BITS),
    .POSITION_BITS     (POSITION_BITS),
    .SAMPLE_COUNT_BITS (SAMPLE_COUNT_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .kind             (kind),
    .stop_sensor      (stop_sensor),
    .load_reading     (load_reading),
    .cmd              (cmd),
    .sts              (sts),
    .step_out         (step_out),
    .direction_out    (direction_out),
    .enable_out       (enable_out),
    .busy_res         (busy_res),
    .phase            (phase),
    .position         (position),
    .zero_offset      (zero_offset),
    .position_valid   (position_valid),
    .sample_valid     (sample_valid),
    .sample_position  (sample_position),
    .sample_reading   (sample_reading),
    .plunge_end_cause (plunge_end_cause)
  );

endmodule

FILE: sim/shps_motion_check.sv
// Motion predictor and result comparison for the stepper homing and plunge sequencer.
module shps_motion_check (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [shps_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  logic [shps_pkg::CFG_DATA_W-1:0]           cfg_data,
  input  logic                                      in_valid,
  input  logic                                      in_ready,
  input  logic [1:0]                                kind,
  input  logic                                      stop_sensor,
  input  logic signed [shps_pkg::READING_BITS_DEF-1:0]  load_reading,
  input  logic                                      out_valid,
  input  logic                                      out_ready,
  input  logic                                      step_out,
  input  logic                                      direction_out,
  input  logic                                      enable_out,
  input  logic                                      busy_res,
  input  logic [1:0]                                phase,
  input  logic signed [shps_pkg::POSITION_BITS_DEF-1:0] position,
  input  logic signed [shps_pkg::READING_BITS_DEF-1:0]  zero_offset,
  input  logic                                      position_valid,
  input  logic                                      sample_valid,
  input  logic signed [shps_pkg::POSITION_BITS_DEF-1:0] sample_position,
  input  logic signed [shps_pkg::READING_BITS_DEF-1:0]  sample_reading,
  input  logic [2:0]                                plunge_end_cause,
  input  logic                                      wrap_up,
  output int                                        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import shps_pkg::*;

  localparam int     RB          = READING_BITS_DEF;
  localparam int     PB          = POSITION_BITS_DEF;
  localparam longint POS_HI      = (longint'(1) << (PB - 1)) - 1;
  localparam longint POS_LO      = -(longint'(1) << (PB - 1));
  localparam longint COUNT_FULL  = (longint'(1) << SAMPLE_COUNT_BITS_DEF) - 1;
  localparam int     RUN_CAP     = 65535;

  // One predicted result beat
  typedef struct {
    logic                 step;
    logic                 dir;
    logic                 enable;
    logic                 busy;
    phase_t               ph;
    logic signed [PB-1:0] pos;
    logic signed [RB-1:0] zoff;
    logic                 homed;
    logic                 logged;
    logic signed [PB-1:0] log_pos;
    logic signed [RB-1:0] log_rd;
    cause_t               cause;
  } motion_t;

  motion_t motion_due[$];
  motion_t want;
  int      misses = 0;

  // Register copies
  longint hi_ticks, lo_ticks, home_off, stroke_limit, dev_limit, run_limit;

  // Sequencer state
  phase_t seq_ph;
  cause_t end_cause;
  longint tick_left;
  bit     pulse_hi;
  longint pos_now;
  longint zero_avg;
  bit     homed;
  longint rd_sum;
  longint rd_count;
  int     over_run;
  bit     stop_req;
  bit     rehome;

  assign fail_count = misses;

  function automatic longint clamp_position(input longint p);
    if (p > POS_HI) return POS_HI;
    if (p < POS_LO) return POS_LO;
    return p;
  endfunction

  task automatic begin_homing();
    seq_ph    = PH_UP;
    rd_sum    = 0;
    rd_count  = 0;
    tick_left = 0;
    pulse_hi  = 0;
  endtask

  task automatic start_step();
    pulse_hi  = 1;
    tick_left = (hi_ticks != 0) ? hi_ticks : 1;
  endtask

  task automatic take_reading(input longint r);
    if (rd_count < COUNT_FULL) begin
      rd_sum += r;
      rd_count++;
    end
  endtask

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      misses++;
    end
  endtask

  // Advance the sequencer by one input beat and queue the result it gives
  task automatic advance_motion(input kind_t k, input bit sensor,
                                input logic signed [RB-1:0] rd);
    motion_t m;
    bit      settled;
    bit      ended;
    cause_t  why;
    longint  dev;
    m.step    = 1'b0;
    m.logged  = 1'b0;
    m.log_pos = '0;
    m.log_rd  = '0;
    case (k)
      KIND_HOME: begin
        if (seq_ph == PH_IDLE) begin
          stop_req = 0;
          rehome   = 0;
          begin_homing();
        end
      end
      KIND_PLUNGE: begin
        if (seq_ph == PH_IDLE) begin
          stop_req  = 0;
          end_cause = CAUSE_NONE;
          over_run  = 0;
          tick_left = 0;
          pulse_hi  = 0;
          if (homed) begin
            rehome = 0;
            seq_ph = PH_PLUNGE;
          end else begin
            rehome = 1;
            begin_homing();
          end
        end
      end
      KIND_STOP: begin
        if (seq_ph != PH_IDLE) stop_req = 1;
      end
      default: begin
        if (seq_ph != PH_IDLE) begin
          // chain phase decisions at a step boundary
          if (!pulse_hi && tick_left == 0) begin
            settled = 0;
            while (!settled) begin
              case (seq_ph)
                PH_UP: begin
                  if (stop_req || sensor) begin
                    pos_now = 0;
                    seq_ph  = PH_DOWN;
                  end else begin
                    start_step();
                    settled = 1;
                  end
                end
                PH_DOWN: begin
                  if (!stop_req && pos_now < home_off) begin
                    start_step();
                    settled = 1;
                  end else begin
                    zero_avg = (rd_count != 0) ? rd_sum / rd_count : 0;
                    homed    = 1;
                    if (rehome) begin
                      rehome   = 0;
                      seq_ph   = PH_PLUNGE;
                      over_run = 0;
                    end else begin
                      seq_ph   = PH_IDLE;
                      stop_req = 0;
                      settled  = 1;
                    end
                  end
                end
                PH_PLUNGE: begin
                  why = CAUSE_NONE;
                  if (stop_req) why = CAUSE_STOP;
                  else if (sensor) why = CAUSE_SENSOR;
                  else if (pos_now >= stroke_limit) why = CAUSE_LIMIT;
                  if (why == CAUSE_NONE) begin
                    start_step();
                    settled = 1;
                  end else begin
                    end_cause = why;
                    begin_homing();
                  end
                end
                default: settled = 1;
              endcase
            end
          end
          // run the step in progress
          if (pulse_hi || tick_left != 0) begin
            m.step = pulse_hi;
            tick_left--;
            if (tick_left == 0) begin
              if (pulse_hi) begin
                pulse_hi  = 0;
                tick_left = (lo_ticks != 0) ? lo_ticks : 1;
              end else if (seq_ph == PH_UP) begin
                pos_now = clamp_position(pos_now - 1);
                take_reading(rd);
              end else if (seq_ph == PH_DOWN) begin
                pos_now = clamp_position(pos_now + 1);
                take_reading(rd);
              end else if (seq_ph == PH_PLUNGE) begin
                dev = rd - zero_avg;
                if (dev < 0) dev = -dev;
                m.logged  = 1'b1;
                m.log_pos = pos_now[PB-1:0];
                m.log_rd  = rd;
                ended     = 0;
                if (dev > dev_limit) begin
                  if (over_run < RUN_CAP) over_run++;
                  ended = (over_run >= run_limit);
                end else begin
                  over_run = 0;
                end
                if (ended) begin
                  end_cause = CAUSE_OVERLOAD;
                  begin_homing();
                end else begin
                  pos_now = clamp_position(pos_now + 1);
                end
              end
            end
          end
        end
      end
    endcase
    m.dir    = (seq_ph == PH_IDLE) ? homed : (seq_ph != PH_UP);
    m.enable = (seq_ph != PH_IDLE);
    m.busy   = (seq_ph != PH_IDLE);
    m.ph     = seq_ph;
    m.pos    = pos_now[PB-1:0];
    m.zoff   = zero_avg[RB-1:0];
    m.homed  = homed;
    m.cause  = end_cause;
    motion_due.insert(motion_due.size(), m);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hi_ticks     = STEP_HIGH_RST;
      lo_ticks     = STEP_LOW_RST;
      home_off     = HOME_OFFSET_RST;
      stroke_limit = PLUNGE_LIMIT_RST;
      dev_limit    = DEV_LIMIT_RST;
      run_limit    = RUN_LIMIT_RST;
      seq_ph       = PH_IDLE;
      end_cause    = CAUSE_NONE;
      tick_left    = 0;
      pulse_hi     = 0;
      pos_now      = 0;
      zero_avg     = 0;
      homed        = 0;
      rd_sum       = 0;
      rd_count     = 0;
      over_run     = 0;
      stop_req     = 0;
      rehome       = 0;
      motion_due.delete();
    end else begin
      // track register writes
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_STEP_HIGH:    hi_ticks     = cfg_data[TICKS_W-1:0];
          CFG_STEP_LOW:     lo_ticks     = cfg_data[TICKS_W-1:0];
          CFG_HOME_OFFSET:  home_off     = cfg_data[STEPS_W-1:0];
          CFG_PLUNGE_LIMIT: stroke_limit = cfg_data[STEPS_W-1:0];
          CFG_DEV_LIMIT:    dev_limit    = cfg_data[DEV_LIMIT_W-1:0];
          CFG_RUN_LIMIT:    run_limit    = cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end
      // compare each result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (motion_due.size() == 0) begin
          $error("result beat arrived with nothing predicted");
          misses++;
        end else begin
          want = motion_due.pop_front();
          check_field("step_out",         want.step,    step_out);
          check_field("direction_out",    want.dir,     direction_out);
          check_field("enable_out",       want.enable,  enable_out);
          check_field("busy_res",         want.busy,    busy_res);
          check_field("phase",            want.ph,      phase);
          check_field("position",         want.pos,     position);
          check_field("zero_offset",      want.zoff,    zero_offset);
          check_field("position_valid",   want.homed,   position_valid);
          check_field("sample_valid",     want.logged,  sample_valid);
          check_field("sample_position",  want.log_pos, sample_position);
          check_field("sample_reading",   want.log_rd,  sample_reading);
          check_field("plunge_end_cause", want.cause,   plunge_end_cause);
        end
      end
      if (in_valid && in_ready) advance_motion(kind_t'(kind), stop_sensor, load_reading);
      // anything still predicted at the end never came out
      if (wrap_up && motion_due.size() != 0) begin
        $error("%0d predicted result beats never arrived", motion_due.size());
        misses += motion_due.size();
        motion_due.delete();
      end
    end
  end

endmodule

FILE: sim/stepper_homing_plunge_sequencer_unit_tb.sv
// Stimulus, flow control and verdict for the stepper homing and plunge sequencer.
module stepper_homing_plunge_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shps_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RAND_BEATS   = 160;
  localparam int HOLD_CYCLES  = 400;
  localparam int LONG_HIGH    = 40;
  localparam int LONG_TICKS   = LONG_HIGH + 1;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]                 cfg_index = '0;
  logic [CFG_DATA_W-1:0]                  cfg_data = '0;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic [1:0]                             kind = KIND_TICK;
  logic                                   stop_sensor = 1'b0;
  logic signed [READING_BITS_DEF-1:0]     load_reading = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic                                   step_out;
  logic                                   direction_out;
  logic                                   enable_out;
  logic                                   busy_res;
  logic [1:0]                             phase;
  logic signed [POSITION_BITS_DEF-1:0]    position;
  logic signed [READING_BITS_DEF-1:0]     zero_offset;
  logic                                   position_valid;
  logic                                   sample_valid;
  logic signed [POSITION_BITS_DEF-1:0]    sample_position;
  logic signed [READING_BITS_DEF-1:0]     sample_reading;
  logic [2:0]                             plunge_end_cause;
  logic                                   wrap_up = 1'b0;
  int                                     fail_count;

  // Flow control and bookkeeping
  bit     calm = 1'b0;
  bit     press_arm = 1'b0;
  bit     pressed = 1'b0;
  int     hold_left = 0;
  int     sent_beats = 0;
  int     got_beats = 0;
  int     cycle_count = 0;
  int     settings_used = 0;
  int     span = 1000;
  phase_t last_phase = PH_IDLE;

  // Per-setting register values for the random part
  int unsigned set_high[5]  = '{1, 0, 2, 1, 1};
  int unsigned set_low[5]   = '{1, 0, 3, 2, 1};
  int unsigned set_off[5]   = '{3, 0, 5, 1, 20'hFFFFF};
  int unsigned set_lim[5]   = '{6, 0, 12, 20'hFFFFF, 8};
  int unsigned set_dev[5]   = '{300, 0, 24'hFFFFFF, 1000, 50};
  int unsigned set_run[5]   = '{2, 0, 16'hFFFF, 1, 3};
  int          set_span[5]  = '{400, 3, 100000, 1500, 80};

  stepper_homing_plunge_sequencer_unit dut (.*);

  shps_motion_check motion_check (.*);

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Receiver: random stalls, one long hold-off when armed, none while calm
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_beats  <= got_beats + 1;
        last_phase <= phase_t'(phase);
      end
      if (press_arm && !pressed) begin
        pressed   <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  function automatic int rand_reading(input int width);
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
      1, 2:    return int'($urandom());
      default: return int'($urandom_range(0, 2 * width)) - width;
    endcase
  endfunction

  // Offer one beat, idling first at random, and hold it until taken
  task automatic send_beat(input kind_t k, input bit s, input int r);
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    stop_sensor  <= s;
    load_reading <= r[READING_BITS_DEF-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_beats++;
  endtask

  task automatic wait_results();
    while (got_beats != sent_beats) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned hi, input int unsigned lo,
                           input int unsigned off, input int unsigned lim,
                           input int unsigned dev, input int unsigned run);
    write_reg(CFG_STEP_HIGH, hi);
    write_reg(CFG_STEP_LOW, lo);
    write_reg(CFG_HOME_OFFSET, off);
    write_reg(CFG_PLUNGE_LIMIT, lim);
    write_reg(CFG_DEV_LIMIT, dev);
    write_reg(CFG_RUN_LIMIT, run);
    cfg_we <= 1'b0;
    settings_used++;
    @(posedge clk);
  endtask

  // Stop whatever runs and tick until the sequencer reports idle
  task automatic settle_idle();
    bit done;
    done = 0;
    send_beat(KIND_STOP, 1'b0, 0);
    while (!done) begin
      in_valid <= 1'b0;
      wait_results();
      if (last_phase == PH_IDLE) done = 1;
      else send_beat(KIND_TICK, 1'($urandom_range(0, 1)), rand_reading(span));
    end
  endtask

  // Random beats: mostly ticks, so sequences run deep, with commands as noise
  task automatic random_beat();
    int  pick;
    bit  s;
    pick = $urandom_range(0, 99);
    s    = ($urandom_range(0, 99) < 12);
    if (pick < 6)       send_beat(KIND_HOME, s, rand_reading(span));
    else if (pick < 12) send_beat(KIND_PLUNGE, s, rand_reading(span));
    else if (pick < 16) send_beat(KIND_STOP, s, rand_reading(span));
    else                send_beat(KIND_TICK, s, rand_reading(span));
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("run stalled: %0d beats sent, %0d results seen", sent_beats, got_beats);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle tick and ignored stop at reset settings
    send_beat(KIND_TICK, 1'b0, 0);
    send_beat(KIND_STOP, 1'b1, -1);
    in_valid <= 1'b0;
    wait_results();

    // directed: plunge before homing, extreme readings, ignored commands,
    // step limit end, stop during homing down, sensor end of a plunge
    configure(1, 1, 2, 3, 100, 2);
    send_beat(KIND_PLUNGE, 1'b0, 0);
    send_beat(KIND_TICK, 1'b0, -8388608);
    send_beat(KIND_TICK, 1'b0, -8388608);
    send_beat(KIND_TICK, 1'b0, 8388607);
    send_beat(KIND_TICK, 1'b0, 8388607);
    send_beat(KIND_HOME, 1'b0, 0);
    send_beat(KIND_TICK, 1'b1, 0);
    send_beat(KIND_TICK, 1'b0, 3);
    send_beat(KIND_TICK, 1'b0, 0);
    send_beat(KIND_TICK, 1'b0, 3);
    send_beat(KIND_TICK, 1'b0, 0);
    send_beat(KIND_TICK, 1'b0, 500);
    send_beat(KIND_PLUNGE, 1'b0, 0);
    send_beat(KIND_TICK, 1'b0, 0);
    send_beat(KIND_TICK, 1'b0, -500);
    send_beat(KIND_TICK, 1'b1, 0);
    send_beat(KIND_TICK, 1'b0, -7);
    send_beat(KIND_TICK, 1'b0, 0);
    send_beat(KIND_STOP, 1'b0, 0);
    send_beat(KIND_TICK, 1'b0, -7);
    send_beat(KIND_TICK, 1'b0, 0);
    send_beat(KIND_PLUNGE, 1'b0, 0);
    send_beat(KIND_TICK, 1'b1, 0);
    settle_idle();

    // random beats under several register settings
    for (int p = 0; p < 5; p++) begin
      configure(set_high[p], set_low[p], set_off[p], set_lim[p], set_dev[p], set_run[p]);
      span = set_span[p];
      for (int n = 0; n < RAND_BEATS; n++) begin
        if (p == 0 && n == 60) press_arm <= 1'b1;
        random_beat();
      end
      settle_idle();
    end

    // one homing with a long high pulse, no idling on either side
    calm <= 1'b1;
    span = 1000;
    configure(LONG_HIGH, 0, 0, 20'hFFFFF, 100000, 1);
    send_beat(KIND_HOME, 1'b0, rand_reading(span));
    for (int n = 0; n < LONG_TICKS; n++) send_beat(KIND_TICK, 1'b0, rand_reading(span));
    repeat (4) send_beat(KIND_TICK, 1'b1, rand_reading(span));
    settle_idle();
    calm <= 1'b0;

    // drain and let the block fall quiet
    in_valid <= 1'b0;
    wait_results();
    repeat (100) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d beats under %0d register settings: homing, plunges, stops,",
             sent_beats, settings_used);
    $display("zero-valued timing and limit registers and a %0d-tick step pulse.", LONG_HIGH);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
